### design/slt_pkg.sv
// Shared types and constants for the sorted list table.
// No dependencies; every other file in design/ refers to this package.
package slt_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;

    // Fixed field widths of the ports
    localparam int CMD_W      = 2;
    localparam int VALUE_IN_W = 32;
    localparam int STATUS_W   = 2;
    localparam int POS_W      = 4;
    localparam int COUNT_W    = 5;

    // Internal widths derived from the capacity
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_EMPTY     = 2'd2,
        STS_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_COMPARE = 2'd1,
        ST_COMMIT  = 2'd2
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2
    } op_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    load;
        logic    compare;
        logic    commit;
        op_t     op;
        status_t status;
        logic    use_pos;
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic empty;
        logic full;
        logic found;
    } dp_status_t;

endpackage

### design/slt_dpath.sv
// Datapath of the sorted list table: row of entry cells, parallel compare, shift update
// and the result register. Depends on slt_pkg.
module slt_dpath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [slt_pkg::VALUE_IN_W-1:0] value,
    input  slt_pkg::ctl_cmd_t             ctl,
    output slt_pkg::dp_status_t           dps,
    output logic [slt_pkg::STATUS_W-1:0]  status,
    output logic [slt_pkg::POS_W-1:0]     position,
    output logic [slt_pkg::COUNT_W-1:0]   entry_count
);

    logic [slt_pkg::VALUE_WIDTH-1:0] ent_reg  [slt_pkg::CAPACITY];
    logic [slt_pkg::VALUE_WIDTH-1:0] ent_next [slt_pkg::CAPACITY];
    logic [slt_pkg::VALUE_WIDTH-1:0] prev_ent [slt_pkg::CAPACITY];
    logic [slt_pkg::VALUE_WIDTH-1:0] succ_ent [slt_pkg::CAPACITY];
    logic [slt_pkg::VALUE_WIDTH-1:0] key_reg;
    logic [slt_pkg::CNT_W-1:0]       count_reg;
    logic [slt_pkg::CNT_W-1:0]       count_next;
    logic [slt_pkg::CAPACITY-1:0]    lt_reg;
    logic [slt_pkg::CAPACITY-1:0]    lt_next;
    logic [slt_pkg::CAPACITY-1:0]    eq_reg;
    logic [slt_pkg::CAPACITY-1:0]    eq_next;
    logic [slt_pkg::CAPACITY-1:0]    bnd;
    logic [slt_pkg::IDX_W-1:0]       bnd_idx;
    slt_pkg::status_t                status_reg;
    logic [slt_pkg::POS_W-1:0]       position_reg;
    logic [slt_pkg::COUNT_W-1:0]     entry_count_reg;

    // Per-cell compare against the key; cells past the count never match
    always_comb
    begin
        for (int i = 0; i < slt_pkg::CAPACITY; i++)
        begin
            lt_next[i] = (slt_pkg::CNT_W'(i) < count_reg) && (ent_reg[i] < key_reg);
            eq_next[i] = (slt_pkg::CNT_W'(i) < count_reg) && (ent_reg[i] == key_reg);
        end
    end

    // lt is a thermometer: the boundary is the first cell that is not smaller
    always_comb
    begin
        bnd_idx = '0;
        for (int i = 0; i < slt_pkg::CAPACITY; i++)
        begin
            if (i == 0)
            begin
                bnd[i] = !lt_reg[i];
            end
            else
            begin
                bnd[i] = !lt_reg[i] && lt_reg[i-1];
            end
            if (bnd[i])
            begin
                bnd_idx = bnd_idx | slt_pkg::IDX_W'(i);
            end
        end
    end

    assign dps.empty = (count_reg == '0);
    assign dps.full  = (count_reg == slt_pkg::CNT_W'(slt_pkg::CAPACITY));
    assign dps.found = |(bnd & eq_reg);

    // Neighbor taps for shifting up on insert and down on delete
    always_comb
    begin
        prev_ent[0] = key_reg;
        for (int i = 1; i < slt_pkg::CAPACITY; i++)
        begin
            prev_ent[i] = ent_reg[i-1];
        end
        for (int i = 0; i < slt_pkg::CAPACITY - 1; i++)
        begin
            succ_ent[i] = ent_reg[i+1];
        end
        succ_ent[slt_pkg::CAPACITY-1] = ent_reg[slt_pkg::CAPACITY-1];
    end

    always_comb
    begin
        count_next = count_reg;
        for (int i = 0; i < slt_pkg::CAPACITY; i++)
        begin
            ent_next[i] = ent_reg[i];
        end
        case (ctl.op)
            slt_pkg::OP_INSERT:
            begin
                count_next = count_reg + 1'b1;
                for (int i = 0; i < slt_pkg::CAPACITY; i++)
                begin
                    if (bnd[i])
                    begin
                        ent_next[i] = key_reg;
                    end
                    else if (!lt_reg[i])
                    begin
                        ent_next[i] = prev_ent[i];
                    end
                end
            end
            slt_pkg::OP_DELETE:
            begin
                count_next = count_reg - 1'b1;
                for (int i = 0; i < slt_pkg::CAPACITY; i++)
                begin
                    if (!lt_reg[i])
                    begin
                        ent_next[i] = succ_ent[i];
                    end
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctl.commit)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            key_reg <= slt_pkg::VALUE_WIDTH'(value);
        end
        if (ctl.compare)
        begin
            lt_reg <= lt_next;
            eq_reg <= eq_next;
        end
        if (ctl.commit)
        begin
            for (int i = 0; i < slt_pkg::CAPACITY; i++)
            begin
                ent_reg[i] <= ent_next[i];
            end
            status_reg      <= ctl.status;
            position_reg    <= ctl.use_pos ? slt_pkg::POS_W'(bnd_idx) : '0;
            entry_count_reg <= slt_pkg::COUNT_W'(count_next);
        end
    end

    assign status      = status_reg;
    assign position    = position_reg;
    assign entry_count = entry_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= slt_pkg::CNT_W'(slt_pkg::CAPACITY))
        else $error("entry count beyond capacity");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.commit && ctl.op == slt_pkg::OP_INSERT) |-> !dps.full)
        else $error("insert committed into a full table");

    a_delete_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.commit && ctl.op == slt_pkg::OP_DELETE) |-> (dps.found && !dps.empty))
        else $error("delete committed without a match");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.commit && ctl.op == slt_pkg::OP_INSERT) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not advance the count");

endmodule

### design/slt_ctrl.sv
// Controller of the sorted list table: command sequencing and output valid.
// Depends on slt_pkg; drives slt_dpath through ctl_cmd_t.
module slt_ctrl
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [slt_pkg::CMD_W-1:0] cmd,
    output logic                     out_valid,
    input  logic                     out_stall,
    output slt_pkg::ctl_cmd_t        ctl,
    input  slt_pkg::dp_status_t      dps
);

    slt_pkg::state_t state_reg;
    slt_pkg::state_t state_next;
    slt_pkg::cmd_t   cmd_reg;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            accept;
    logic            out_free;

    assign in_stall = (state_reg != slt_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        ctl.load       = 1'b0;
        ctl.compare    = 1'b0;
        ctl.commit     = 1'b0;
        ctl.op         = slt_pkg::OP_NONE;
        ctl.status     = slt_pkg::STS_OK;
        ctl.use_pos    = 1'b0;
        out_valid_next = out_valid_reg && out_stall;

        // Decode the result for the held command
        case (cmd_reg)
            slt_pkg::CMD_INSERT:
            begin
                if (dps.full)
                begin
                    ctl.status = slt_pkg::STS_FULL;
                end
                else
                begin
                    ctl.op      = slt_pkg::OP_INSERT;
                    ctl.use_pos = 1'b1;
                end
            end
            slt_pkg::CMD_FIND, slt_pkg::CMD_DELETE:
            begin
                if (dps.empty)
                begin
                    ctl.status = slt_pkg::STS_EMPTY;
                end
                else if (!dps.found)
                begin
                    ctl.status = slt_pkg::STS_NOT_FOUND;
                end
                else
                begin
                    ctl.use_pos = 1'b1;
                    if (cmd_reg == slt_pkg::CMD_DELETE)
                    begin
                        ctl.op = slt_pkg::OP_DELETE;
                    end
                end
            end
            default:
            begin
                ctl.status = slt_pkg::STS_OK;
            end
        endcase

        case (state_reg)
            slt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    ctl.load   = 1'b1;
                    state_next = slt_pkg::ST_COMPARE;
                end
            end
            slt_pkg::ST_COMPARE:
            begin
                ctl.compare = 1'b1;
                state_next  = slt_pkg::ST_COMMIT;
            end
            slt_pkg::ST_COMMIT:
            begin
                // Hold until the result register is free
                if (out_free)
                begin
                    ctl.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = slt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = slt_pkg::ST_IDLE;
            end
        endcase

        if (!ctl.commit)
        begin
            ctl.op = slt_pkg::OP_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= slt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= slt_pkg::cmd_t'(cmd);
        end
    end

    assign out_valid = out_valid_reg;

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |-> !(out_valid_reg && out_stall))
        else $error("result overwritten while stalled");

    a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 (state_reg == slt_pkg::ST_COMMIT))
        else $error("compare step skipped");

    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |=> out_valid_reg)
        else $error("committed result not presented");

endmodule

### design/sorted_list_table.sv
// Top level of the sorted list table: ties the controller to the datapath.
// Depends on slt_pkg, slt_ctrl and slt_dpath.
//
// Sorted list table: holds up to CAPACITY unsigned keys in ascending order in a
// row of register cells. Each transfer on the input channel carries one command:
// insert (kept sorted, a new key goes ahead of any equal keys already stored),
// find (first occurrence) or delete (first occurrence). Every command yields
// exactly one result transfer with status (ok, not found, empty, full), the
// sorted position of the entry touched (zero unless ok) and the entry count
// after the command. A command passes through capture at the input transfer,
// a registered parallel compare of all cells against the key, and a commit
// that shifts the row and loads the result register; the commit waits while
// an earlier result is still held under stall. A new command is taken only
// once the previous one has committed; a result waiting under stall holds the
// row's update of the next command, not its capture. After reset the table is
// empty; no clearing pass is needed.
module sorted_list_table
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [slt_pkg::CMD_W-1:0]       cmd,
    input  logic [slt_pkg::VALUE_IN_W-1:0]  value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [slt_pkg::STATUS_W-1:0]    status,
    output logic [slt_pkg::POS_W-1:0]       position,
    output logic [slt_pkg::COUNT_W-1:0]     entry_count
);

    slt_pkg::ctl_cmd_t   ctl;
    slt_pkg::dp_status_t dps;

    // Sequence capture, compare and commit; own the output valid
    slt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctl       (ctl),
        .dps       (dps)
    );

    // Hold the entries, compare, shift and register the result payload
    slt_dpath u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .ctl         (ctl),
        .dps         (dps),
        .status      (status),
        .position    (position),
        .entry_count (entry_count)
    );

endmodule
